FILE: rtl/uqt_pkg.sv
package uqt_pkg;

    // Parser modes, one-hot
    typedef enum logic [4:0] {
        MODE_SEEK  = 5'b00001,
        MODE_PATH  = 5'b00010,
        MODE_KEY   = 5'b00100,
        MODE_VALUE = 5'b01000,
        MODE_SKIP  = 5'b10000
    } mode_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PATH_BYTE  = 3'd0,
        KIND_KEY_BYTE   = 3'd1,
        KIND_VALUE_BYTE = 3'd2,
        KIND_PATH_DONE  = 3'd3,
        KIND_KEY_DONE   = 3'd4,
        KIND_VALUE_DONE = 3'd5,
        KIND_URL_END    = 3'd6
    } kind_t;

    // URL end status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_URL      = 2'd1,
        ST_KEY_NO_EQ   = 2'd2,
        ST_TOO_LONG    = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_URL_LIMIT   = 2'd0,
        REG_PATH_LIMIT  = 2'd1,
        REG_KEY_LIMIT   = 2'd2,
        REG_VALUE_LIMIT = 2'd3
    } reg_idx_t;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;

    localparam logic [6:0] LIM_URL_RST   = 7'd99;
    localparam logic [6:0] LIM_PATH_RST  = 7'd29;
    localparam logic [6:0] LIM_KEY_RST   = 7'd9;
    localparam logic [6:0] LIM_VALUE_RST = 7'd9;

    typedef struct packed {
        logic [6:0] url_limit;
        logic [6:0] path_limit;
        logic [6:0] key_limit;
        logic [6:0] value_limit;
    } limits_t;

    // One result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [5:0] pair_index;
        logic [6:0] offset;
        logic       over_limit;
        status_t    status;
        logic [5:0] pair_count;
    } item_t;

    // All results caused by one request byte
    typedef struct packed {
        logic [1:0]      cnt;
        item_t [2:0]     items;
    } bundle_t;

endpackage

FILE: rtl/uqt_parser.sv
module uqt_parser (
    input  uqt_pkg::mode_t   mode,
    input  logic [6:0]       url_len,
    input  logic [6:0]       tok_off,
    input  logic [5:0]       pairs,
    input  uqt_pkg::limits_t limits,
    input  logic [7:0]       in_byte,
    input  logic             eor,
    output uqt_pkg::mode_t   mode_next,
    output logic [6:0]       url_len_next,
    output logic [6:0]       tok_off_next,
    output logic [5:0]       pairs_next,
    output uqt_pkg::bundle_t bundle
);

    typedef struct packed {
        logic [1:0]     cnt;
        uqt_pkg::item_t a;
        uqt_pkg::item_t b;
        logic [5:0]     pairs;
    } close_t;

    function automatic logic [6:0] sat7(input logic [6:0] v);
        sat7 = (v == 7'd127) ? v : v + 7'd1;
    endfunction

    function automatic logic [5:0] sat6(input logic [5:0] v);
        sat6 = (v == 6'd63) ? v : v + 6'd1;
    endfunction

    function automatic uqt_pkg::item_t mk_byte(input uqt_pkg::kind_t k, input logic [7:0] b,
                                               input logic [5:0] pi, input logic [6:0] off,
                                               input logic [6:0] lim);
        uqt_pkg::item_t it;
        it            = '0;
        it.kind       = k;
        it.data       = b;
        it.pair_index = pi;
        it.offset     = off;
        it.over_limit = (off >= lim);
        return it;
    endfunction

    function automatic uqt_pkg::item_t mk_mark(input uqt_pkg::kind_t k, input logic [5:0] pi,
                                               input logic [6:0] off);
        uqt_pkg::item_t it;
        it            = '0;
        it.kind       = k;
        it.pair_index = pi;
        it.offset     = off;
        return it;
    endfunction

    function automatic uqt_pkg::item_t mk_end(input logic [5:0] pc, input logic [6:0] len,
                                              input uqt_pkg::status_t st);
        uqt_pkg::item_t it;
        it            = '0;
        it.kind       = uqt_pkg::KIND_URL_END;
        it.pair_index = pc;
        it.offset     = len;
        it.status     = st;
        it.pair_count = pc;
        return it;
    endfunction

    // Done marker for the open token, if there is one, then the URL end item
    function automatic close_t close_url(input uqt_pkg::mode_t m, input logic [6:0] tok,
                                         input logic [5:0] pr, input logic [6:0] len);
        close_t c;
        logic [5:0] p2;
        c       = '0;
        c.pairs = pr;
        p2      = sat6(pr);
        unique case (m)
            uqt_pkg::MODE_PATH: begin
                c.a   = mk_mark(uqt_pkg::KIND_PATH_DONE, 6'd0, tok);
                c.b   = mk_end(pr, len, uqt_pkg::ST_OK);
                c.cnt = 2'd2;
            end
            uqt_pkg::MODE_KEY: begin
                if (tok != 7'd0) begin
                    c.a   = mk_mark(uqt_pkg::KIND_KEY_DONE, pr, tok);
                    c.b   = mk_end(pr, len, uqt_pkg::ST_KEY_NO_EQ);
                    c.cnt = 2'd2;
                end else begin
                    c.a   = mk_end(pr, len, uqt_pkg::ST_OK);
                    c.cnt = 2'd1;
                end
            end
            uqt_pkg::MODE_VALUE: begin
                c.a     = mk_mark(uqt_pkg::KIND_VALUE_DONE, pr, tok);
                c.b     = mk_end(p2, len, uqt_pkg::ST_OK);
                c.cnt   = 2'd2;
                c.pairs = p2;
            end
            default: begin
                c.a   = mk_end(pr, len, uqt_pkg::ST_OK);
                c.cnt = 2'd1;
            end
        endcase
        return c;
    endfunction

    logic   in_url;
    logic   in_url_next;
    logic   closed;
    close_t cl_first;
    close_t cl_eor;

    // Mode, offsets and counts after the byte itself, before any close
    uqt_pkg::mode_t mode_pre;
    logic [6:0]     url_pre;
    logic [6:0]     tok_pre;
    logic [5:0]     pairs_pre;

    assign in_url = (mode == uqt_pkg::MODE_PATH) || (mode == uqt_pkg::MODE_KEY)
                 || (mode == uqt_pkg::MODE_VALUE);

    assign cl_first = close_url(mode, tok_off, pairs, url_len);

    // Per-byte mode update and result generation
    always_comb begin
        mode_next    = mode;
        url_len_next = url_len;
        tok_off_next = tok_off;
        pairs_next   = pairs;
        bundle       = '0;
        closed       = 1'b0;

        if (in_url) begin
            if (in_byte == uqt_pkg::CH_SPACE) begin
                bundle.items[0] = cl_first.a;
                bundle.items[1] = cl_first.b;
                bundle.cnt      = cl_first.cnt;
                pairs_next      = cl_first.pairs;
                closed          = 1'b1;
            end else if (url_len >= limits.url_limit) begin
                bundle.items[0] = mk_end(pairs, url_len, uqt_pkg::ST_TOO_LONG);
                bundle.cnt      = 2'd1;
                closed          = 1'b1;
            end else begin
                url_len_next = url_len + 7'd1;
                bundle.cnt   = 2'd1;
                unique case (mode)
                    uqt_pkg::MODE_PATH: begin
                        if (in_byte == uqt_pkg::CH_QUEST) begin
                            bundle.items[0] = mk_mark(uqt_pkg::KIND_PATH_DONE, 6'd0, tok_off);
                            mode_next       = uqt_pkg::MODE_KEY;
                            tok_off_next    = 7'd0;
                        end else begin
                            bundle.items[0] = mk_byte(uqt_pkg::KIND_PATH_BYTE, in_byte, 6'd0,
                                                      tok_off, limits.path_limit);
                            tok_off_next    = sat7(tok_off);
                        end
                    end
                    uqt_pkg::MODE_KEY: begin
                        if (in_byte == uqt_pkg::CH_EQUAL) begin
                            bundle.items[0] = mk_mark(uqt_pkg::KIND_KEY_DONE, pairs, tok_off);
                            mode_next       = uqt_pkg::MODE_VALUE;
                            tok_off_next    = 7'd0;
                        end else begin
                            bundle.items[0] = mk_byte(uqt_pkg::KIND_KEY_BYTE, in_byte, pairs,
                                                      tok_off, limits.key_limit);
                            tok_off_next    = sat7(tok_off);
                        end
                    end
                    default: begin
                        if (in_byte == uqt_pkg::CH_AMP) begin
                            bundle.items[0] = mk_mark(uqt_pkg::KIND_VALUE_DONE, pairs, tok_off);
                            pairs_next      = sat6(pairs);
                            mode_next       = uqt_pkg::MODE_KEY;
                            tok_off_next    = 7'd0;
                        end else begin
                            bundle.items[0] = mk_byte(uqt_pkg::KIND_VALUE_BYTE, in_byte, pairs,
                                                      tok_off, limits.value_limit);
                            tok_off_next    = sat7(tok_off);
                        end
                    end
                endcase
            end
        end else if (mode != uqt_pkg::MODE_SKIP) begin
            mode_next = uqt_pkg::MODE_SEEK;
            if (in_byte == uqt_pkg::CH_SLASH) begin
                pairs_next   = 6'd0;
                tok_off_next = 7'd0;
                url_len_next = 7'd0;
                bundle.cnt   = 2'd1;
                if (limits.url_limit == 7'd0) begin
                    bundle.items[0] = mk_end(6'd0, 7'd0, uqt_pkg::ST_TOO_LONG);
                    closed          = 1'b1;
                end else begin
                    url_len_next    = 7'd1;
                    mode_next       = uqt_pkg::MODE_PATH;
                    bundle.items[0] = mk_byte(uqt_pkg::KIND_PATH_BYTE, in_byte, 6'd0, 7'd0,
                                              limits.path_limit);
                    tok_off_next    = 7'd1;
                end
            end else if (eor) begin
                bundle.items[0] = mk_end(6'd0, 7'd0, uqt_pkg::ST_NO_URL);
                bundle.cnt      = 2'd1;
            end
        end

        // End of request closes a URL still open after this byte
        if (eor && !closed && in_url_next) begin
            bundle.items[bundle.cnt] = cl_eor.a;
            if (cl_eor.cnt == 2'd2) begin
                bundle.items[bundle.cnt + 2'd1] = cl_eor.b;
            end
            bundle.cnt = bundle.cnt + cl_eor.cnt;
            pairs_next = cl_eor.pairs;
            closed     = 1'b1;
        end

        if (closed) begin
            mode_next    = uqt_pkg::MODE_SKIP;
            url_len_next = 7'd0;
            tok_off_next = 7'd0;
        end
        if (eor) begin
            mode_next    = uqt_pkg::MODE_SEEK;
            url_len_next = 7'd0;
            tok_off_next = 7'd0;
        end
    end

    // Close on end of request sees the state left by this byte
    always_comb begin
        in_url_next = 1'b0;
        unique case (mode_pre)
            uqt_pkg::MODE_PATH, uqt_pkg::MODE_KEY, uqt_pkg::MODE_VALUE: in_url_next = 1'b1;
            default: in_url_next = 1'b0;
        endcase
    end

    always_comb begin
        mode_pre  = mode;
        url_pre   = url_len;
        tok_pre   = tok_off;
        pairs_pre = pairs;
        if (in_url) begin
            if ((in_byte != uqt_pkg::CH_SPACE) && (url_len < limits.url_limit)) begin
                url_pre = url_len + 7'd1;
                unique case (mode)
                    uqt_pkg::MODE_PATH: begin
                        if (in_byte == uqt_pkg::CH_QUEST) begin
                            mode_pre = uqt_pkg::MODE_KEY;
                            tok_pre  = 7'd0;
                        end else begin
                            tok_pre  = sat7(tok_off);
                        end
                    end
                    uqt_pkg::MODE_KEY: begin
                        if (in_byte == uqt_pkg::CH_EQUAL) begin
                            mode_pre = uqt_pkg::MODE_VALUE;
                            tok_pre  = 7'd0;
                        end else begin
                            tok_pre  = sat7(tok_off);
                        end
                    end
                    default: begin
                        if (in_byte == uqt_pkg::CH_AMP) begin
                            mode_pre  = uqt_pkg::MODE_KEY;
                            pairs_pre = sat6(pairs);
                            tok_pre   = 7'd0;
                        end else begin
                            tok_pre   = sat7(tok_off);
                        end
                    end
                endcase
            end
        end else if ((mode != uqt_pkg::MODE_SKIP) && (in_byte == uqt_pkg::CH_SLASH)
                     && (limits.url_limit != 7'd0)) begin
            mode_pre  = uqt_pkg::MODE_PATH;
            url_pre   = 7'd1;
            tok_pre   = 7'd1;
            pairs_pre = 6'd0;
        end
    end

    assign cl_eor = close_url(mode_pre, tok_pre, pairs_pre, url_pre);

endmodule

FILE: rtl/uqt_outbuf.sv
module uqt_outbuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  uqt_pkg::bundle_t push_bundle,
    output logic             full,
    output logic             m_valid,
    input  logic             m_ready,
    output uqt_pkg::item_t   m_item,
    output logic             m_last
);

    uqt_pkg::bundle_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    uqt_pkg::bundle_t head;
    logic             take;
    logic             pop;

    assign head    = slot_reg[rd_ptr_reg];
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_item  = head.items[idx_reg];
    assign m_last  = (idx_reg == (head.cnt - 2'd1));
    assign take    = m_valid && m_ready;
    assign pop     = take && m_last;

    // Pointer, fill and item index update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        idx_next    = idx_reg;
        if (take) begin
            idx_next = m_last ? 2'd0 : idx_reg + 2'd1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

    // Bundle storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

`ifndef SYNTH
    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg < head.cnt))
        else $error("item index past end of bundle");
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.kind == uqt_pkg::KIND_URL_END)) |-> m_last)
        else $error("url end not last of its request");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full result buffer");
`endif

endmodule

FILE: rtl/url_query_tokenizer_core.sv
// The results of a request byte are written into the 2-entry result buffer on accept and
// reach the m_ side after any earlier results still waiting there.
// Throughput: one byte per cycle while each byte gives at most one result and m_ready is high;
// a byte giving two or three results sends them one at a time on the single result port.
// Reset (aresetn low, synchronous): parser seeks the first '/', limits return to
// 99/29/9/9, result buffer empties.
module url_query_tokenizer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_request,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [5:0] m_pair_index,
    output logic [6:0] m_offset,
    output logic       m_over_limit,
    output logic [1:0] m_status,
    output logic [5:0] m_pair_count,
    output logic       m_last
);

    uqt_pkg::limits_t limits_reg;
    uqt_pkg::mode_t   mode_reg;
    uqt_pkg::mode_t   mode_next;
    logic [6:0]       url_len_reg;
    logic [6:0]       url_len_next;
    logic [6:0]       tok_off_reg;
    logic [6:0]       tok_off_next;
    logic [5:0]       pairs_reg;
    logic [5:0]       pairs_next;
    uqt_pkg::bundle_t bundle;
    uqt_pkg::item_t   item;
    logic             full;
    logic             accept;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.url_limit   <= uqt_pkg::LIM_URL_RST;
            limits_reg.path_limit  <= uqt_pkg::LIM_PATH_RST;
            limits_reg.key_limit   <= uqt_pkg::LIM_KEY_RST;
            limits_reg.value_limit <= uqt_pkg::LIM_VALUE_RST;
        end else if (cfg_wr_en) begin
            unique case (uqt_pkg::reg_idx_t'(cfg_index))
                uqt_pkg::REG_URL_LIMIT:   limits_reg.url_limit   <= cfg_wdata;
                uqt_pkg::REG_PATH_LIMIT:  limits_reg.path_limit  <= cfg_wdata;
                uqt_pkg::REG_KEY_LIMIT:   limits_reg.key_limit   <= cfg_wdata;
                uqt_pkg::REG_VALUE_LIMIT: limits_reg.value_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    uqt_parser u_parser (
        .mode         (mode_reg),
        .url_len      (url_len_reg),
        .tok_off      (tok_off_reg),
        .pairs        (pairs_reg),
        .limits       (limits_reg),
        .in_byte      (s_in_byte),
        .eor          (s_end_of_request),
        .mode_next    (mode_next),
        .url_len_next (url_len_next),
        .tok_off_next (tok_off_next),
        .pairs_next   (pairs_next),
        .bundle       (bundle)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= uqt_pkg::MODE_SEEK;
            url_len_reg <= 7'd0;
            tok_off_reg <= 7'd0;
            pairs_reg   <= 6'd0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            url_len_reg <= url_len_next;
            tok_off_reg <= tok_off_next;
            pairs_reg   <= pairs_next;
        end
    end

    uqt_outbuf u_outbuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (accept && (bundle.cnt != 2'd0)),
        .push_bundle (bundle),
        .full        (full),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (item),
        .m_last      (m_last)
    );

    assign m_kind       = item.kind;
    assign m_out_byte   = item.data;
    assign m_pair_index = item.pair_index;
    assign m_offset     = item.offset;
    assign m_over_limit = item.over_limit;
    assign m_status     = item.status;
    assign m_pair_count = item.pair_count;

`ifndef SYNTH
    a_eor_reseeks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_request) |=>
            ((mode_reg == uqt_pkg::MODE_SEEK) && (url_len_reg == 7'd0)))
        else $error("end of request did not return to seeking");
    a_skip_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (mode_reg == uqt_pkg::MODE_SKIP) && !s_end_of_request)
            |-> (bundle.cnt == 2'd0))
        else $error("result produced while skipping");
`endif

endmodule
